[rtl/core/fpbp_pkg.sv]
// Shared constants and types for the framed packet byte parser.
package fpbp_pkg;

   localparam logic [7:0] FRAME_START_BYTE = 8'h3a;
   localparam logic [7:0] FRAME_END_FIRST  = 8'h0d;
   localparam logic [7:0] FRAME_END_SECOND = 8'h0a;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ABORT    = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_address;
      logic [15:0] frame_function;
      logic [15:0] frame_length;
      logic [15:0] received_check;
   } rsp_type;

endpackage

[rtl/core/fpbp_if.sv]
// Valid/ready channel interfaces for received bytes and parser results.
interface fpbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [15:0] payload_index;
   logic [15:0] frame_address;
   logic [15:0] frame_function;
   logic [15:0] frame_length;
   logic [15:0] received_check;

   modport source (output valid, output kind, output payload_byte, output payload_index,
                   output frame_address, output frame_function, output frame_length,
                   output received_check, input ready);
   modport sink (input valid, input kind, input payload_byte, input payload_index,
                 input frame_address, input frame_function, input frame_length,
                 input received_check, output ready);
endinterface

[rtl/core/fpbp_in_stage.sv]
// Input register: holds one received byte until the parser takes it.
module fpbp_in_stage (
   input  logic       clock,
   input  logic       reset,
   fpbp_req_if.sink   req_bus,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       take;

   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_bus.rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;
endmodule

[rtl/core/fpbp_parse.sv]
// Frame parser state machine: one byte per step, at most one result per byte.
module fpbp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output logic               res_valid,
   output fpbp_pkg::rsp_type  res
);
   import fpbp_pkg::*;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_ADDR_LO = 4'd1,
      PH_ADDR_HI = 4'd2,
      PH_FUNC_LO = 4'd3,
      PH_FUNC_HI = 4'd4,
      PH_LEN_LO  = 4'd5,
      PH_LEN_HI  = 4'd6,
      PH_PAYLOAD = 4'd7,
      PH_CHK_LO  = 4'd8,
      PH_CHK_HI  = 4'd9,
      PH_END_LO  = 4'd10,
      PH_END_HI  = 4'd11
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] address_ff, address_in;
   logic [15:0] function_ff, function_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] check_ff, check_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] count_next;

   assign count_next = count_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      address_in  = address_ff;
      function_in = function_ff;
      length_in   = length_ff;
      check_in    = check_ff;
      count_in    = count_ff;
      res_valid   = 1'b0;
      res         = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == FRAME_START_BYTE) begin
               phase_in = PH_ADDR_LO;
               count_in = '0;
            end
         end
         PH_ADDR_LO: begin
            address_in = {8'd0, rx_byte};
            phase_in   = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            address_in = {rx_byte, address_ff[7:0]};
            phase_in   = PH_FUNC_LO;
         end
         PH_FUNC_LO: begin
            function_in = {8'd0, rx_byte};
            phase_in    = PH_FUNC_HI;
         end
         PH_FUNC_HI: begin
            function_in = {rx_byte, function_ff[7:0]};
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, rx_byte};
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {rx_byte, length_ff[7:0]};
            // skip the payload phase on an empty frame
            phase_in  = (length_in != 16'd0) ? PH_PAYLOAD : PH_CHK_LO;
         end
         PH_PAYLOAD: begin
            res_valid         = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = rx_byte;
            res.payload_index = count_ff;
            count_in          = count_next;
            if (count_next == length_ff) begin
               count_in = '0;
               phase_in = PH_CHK_LO;
            end
         end
         PH_CHK_LO: begin
            check_in = {8'd0, rx_byte};
            phase_in = PH_CHK_HI;
         end
         PH_CHK_HI: begin
            check_in = {rx_byte, check_ff[7:0]};
            phase_in = PH_END_LO;
         end
         PH_END_LO: begin
            if (rx_byte == FRAME_END_FIRST) begin
               phase_in = PH_END_HI;
            end else begin
               phase_in  = PH_HUNT;
               res_valid = 1'b1;
               res.kind  = KIND_ABORT;
            end
         end
         PH_END_HI: begin
            phase_in  = PH_HUNT;
            res_valid = 1'b1;
            if (rx_byte == FRAME_END_SECOND) begin
               res.kind           = KIND_COMPLETE;
               res.frame_address  = address_ff;
               res.frame_function = function_ff;
               res.frame_length   = length_ff;
               res.received_check = check_ff;
            end else begin
               res.kind = KIND_ABORT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         address_ff  <= '0;
         function_ff <= '0;
         length_ff   <= '0;
         check_ff    <= '0;
         count_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         address_ff  <= address_in;
         function_ff <= function_in;
         length_ff   <= length_in;
         check_ff    <= check_in;
         count_ff    <= count_in;
      end
   end
endmodule

[rtl/core/fpbp_out_stage.sv]
// Result register: holds one result transaction until the sink takes it.
module fpbp_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  fpbp_pkg::rsp_type  res,
   output logic               out_free,
   fpbp_rsp_if.source         rsp_bus
);
   import fpbp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = res;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.kind           = data_ff.kind;
   assign rsp_bus.payload_byte   = data_ff.payload_byte;
   assign rsp_bus.payload_index  = data_ff.payload_index;
   assign rsp_bus.frame_address  = data_ff.frame_address;
   assign rsp_bus.frame_function = data_ff.frame_function;
   assign rsp_bus.frame_length   = data_ff.frame_length;
   assign rsp_bus.received_check = data_ff.received_check;
endmodule

[rtl/core/framed_packet_byte_parser.sv]
// Framed packet byte parser: takes one received byte per transaction and hunts for a
// frame of start byte 0x3a, little-endian address, function code and length, payload,
// check word and end bytes 0x0d 0x0a. Each payload byte comes out with its index; a
// good end gives one frame-complete result with the header and received check word
// (not verified), and a bad end byte gives an abort result and a return to hunting.
// Throughput is one byte per clock cycle while the result register can take a result;
// a byte is held in the input register, then its result is loaded into the result
// register, from which the sink takes it. Back-pressure on the result side stalls
// parsing only when the result register is full and not being taken.
module framed_packet_byte_parser (
   input  logic        clock,
   input  logic        reset,
   fpbp_req_if.sink    req_bus,
   fpbp_rsp_if.source  rsp_bus
);
   import fpbp_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       out_free;
   logic       advance;
   logic       res_valid;
   rsp_type    res;

   // advance the parser whenever a byte is held and the result register can take a result
   assign advance = byte_valid && out_free;

   fpbp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   fpbp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   fpbp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && res_valid),
      .res      (res),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );
endmodule

[rtl/core/fpbp_checker.sv]
// Port-level checks on the parser's result channel, bound to the top level.
module fpbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  kind,
   input logic [7:0]  payload_byte,
   input logic [15:0] payload_index,
   input logic [15:0] frame_address,
   input logic [15:0] frame_function,
   input logic [15:0] frame_length,
   input logic [15:0] received_check
);
   import fpbp_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (kind == KIND_PAYLOAD || kind == KIND_COMPLETE || kind == KIND_ABORT))
      else $error("illegal result kind");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_PAYLOAD |-> frame_address == 16'd0 &&
      frame_function == 16'd0 && frame_length == 16'd0 && received_check == 16'd0)
      else $error("payload result carries header fields");

   a_frame_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && payload_index == 16'd0)
      else $error("frame result carries payload fields");
endmodule

bind framed_packet_byte_parser fpbp_checker u_fpbp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .kind           (rsp_bus.kind),
   .payload_byte   (rsp_bus.payload_byte),
   .payload_index  (rsp_bus.payload_index),
   .frame_address  (rsp_bus.frame_address),
   .frame_function (rsp_bus.frame_function),
   .frame_length   (rsp_bus.frame_length),
   .received_check (rsp_bus.received_check)
);

[tb/framed_packet_byte_parser_test.sv]
// Self-checking testbench for the framed packet byte parser: directed frames, then random traffic.
`timescale 1ns / 100ps

module framed_packet_byte_parser_test;
   import fpbp_pkg::*;

   typedef enum logic [3:0] {
      PS_HUNT, PS_ADDR_LO, PS_ADDR_HI, PS_FUNC_LO, PS_FUNC_HI, PS_LEN_LO, PS_LEN_HI,
      PS_PAYLOAD, PS_CHK_LO, PS_CHK_HI, PS_END_LO, PS_END_HI
   } parse_state_type;

   localparam int unsigned RX_ALWAYS  = 0;
   localparam int unsigned RX_MOSTLY  = 1;
   localparam int unsigned RX_RARELY  = 2;
   localparam int unsigned RX_PERIODIC = 3;

   localparam int unsigned RANDOM_ITEMS = 1150;

   logic clock;
   logic reset;

   fpbp_req_if req_bus ();
   fpbp_rsp_if rsp_bus ();

   framed_packet_byte_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // parser state as predicted
   parse_state_type parse_state = PS_HUNT;
   logic [15:0]  address_word = '0;
   logic [15:0]  function_word = '0;
   logic [15:0]  length_word = '0;
   logic [15:0]  check_word = '0;
   logic [15:0]  payload_count = '0;

   rsp_type     pending_results[$];
   int unsigned error_count = 0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;

   int unsigned stall_mode = RX_ALWAYS;
   int unsigned stall_left = 0;
   int unsigned stall_cycle = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("framed_packet_byte_parser_test: FAIL");
      $finish;
   end

   function automatic void predict_byte(input logic [7:0] b);
      rsp_type     r;
      logic [15:0] hi;
      r = '0;
      hi = {b, 8'h00};
      case (parse_state)
         PS_HUNT: begin
            if (b == FRAME_START_BYTE) begin
               parse_state = PS_ADDR_LO;
               payload_count = '0;
            end
         end
         PS_ADDR_LO: begin
            address_word = {8'h00, b};
            parse_state = PS_ADDR_HI;
         end
         PS_ADDR_HI: begin
            address_word = address_word | hi;
            parse_state = PS_FUNC_LO;
         end
         PS_FUNC_LO: begin
            function_word = {8'h00, b};
            parse_state = PS_FUNC_HI;
         end
         PS_FUNC_HI: begin
            function_word = function_word | hi;
            parse_state = PS_LEN_LO;
         end
         PS_LEN_LO: begin
            length_word = {8'h00, b};
            parse_state = PS_LEN_HI;
         end
         PS_LEN_HI: begin
            length_word = length_word | hi;
            parse_state = (length_word != 16'd0) ? PS_PAYLOAD : PS_CHK_LO;
         end
         PS_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.payload_index = payload_count;
            payload_count = payload_count + 16'd1;
            if (payload_count == length_word) begin
               payload_count = '0;
               parse_state = PS_CHK_LO;
            end
            pending_results.push_back(r);
         end
         PS_CHK_LO: begin
            check_word = {8'h00, b};
            parse_state = PS_CHK_HI;
         end
         PS_CHK_HI: begin
            check_word = check_word | hi;
            parse_state = PS_END_LO;
         end
         PS_END_LO: begin
            if (b == FRAME_END_FIRST) begin
               parse_state = PS_END_HI;
            end else begin
               // a bad end byte is never taken as a new start
               parse_state = PS_HUNT;
               r.kind = KIND_ABORT;
               pending_results.push_back(r);
            end
         end
         PS_END_HI: begin
            parse_state = PS_HUNT;
            if (b == FRAME_END_SECOND) begin
               r.kind = KIND_COMPLETE;
               r.frame_address = address_word;
               r.frame_function = function_word;
               r.frame_length = length_word;
               r.received_check = check_word;
            end else begin
               r.kind = KIND_ABORT;
            end
            pending_results.push_back(r);
         end
         default: parse_state = PS_HUNT;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_bus.valid = 1'b1;
      req_bus.rx_byte = b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_byte(b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_word(input logic [15:0] w);
      send_byte(w[7:0]);
      send_byte(w[15:8]);
   endtask

   task automatic send_frame(input logic [15:0] addr, input logic [15:0] func,
                             input logic [15:0] len, input logic [15:0] chk,
                             input logic [7:0] end_first, input logic [7:0] end_second);
      send_byte(FRAME_START_BYTE);
      send_word(addr);
      send_word(func);
      send_word(len);
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
      send_word(chk);
      send_byte(end_first);
      // after a bad first end byte the parser is hunting again
      if (end_first == FRAME_END_FIRST) send_byte(end_second);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return {FRAME_END_SECOND, FRAME_START_BYTE};
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [7:0] pick_bad_end(input logic [7:0] good);
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: b = FRAME_START_BYTE;
         1: b = (good == FRAME_END_FIRST) ? FRAME_END_SECOND : FRAME_END_FIRST;
         default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == good) b = ~good;
      return b;
   endfunction

   task automatic test_hunt_noise();
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(FRAME_END_FIRST);
   endtask

   task automatic test_zero_length_frame();
      send_frame(16'hffff, 16'h0000, 16'h0000, 16'ha55a, FRAME_END_FIRST, FRAME_END_SECOND);
   endtask

   task automatic test_bad_second_end();
      send_frame(16'h0000, 16'hffff, 16'h0001, 16'hffff, FRAME_END_FIRST, FRAME_START_BYTE);
   endtask

   task automatic test_bad_first_end();
      // the offending byte is a start byte; it must not open a frame
      send_frame(16'h3a3a, 16'h0d0a, 16'h0000, 16'h0000, FRAME_START_BYTE, FRAME_END_SECOND);
      send_byte(8'h01);
   endtask

   task automatic test_long_frame();
      // length with a nonzero high byte
      send_frame(pick_word(), pick_word(), 16'h0101, pick_word(),
                 FRAME_END_FIRST, FRAME_END_SECOND);
   endtask

   task automatic test_random_frames();
      logic [15:0] len;
      logic [7:0]  noise;
      int unsigned pick;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
         if (pick < 7) begin
            send_frame(pick_word(), pick_word(), len, pick_word(),
                       FRAME_END_FIRST, FRAME_END_SECOND);
         end else if (pick == 7) begin
            send_frame(pick_word(), pick_word(), len, pick_word(),
                       pick_bad_end(FRAME_END_FIRST), FRAME_END_SECOND);
         end else if (pick == 8) begin
            send_frame(pick_word(), pick_word(), len, pick_word(),
                       FRAME_END_FIRST, pick_bad_end(FRAME_END_SECOND));
         end else begin
            // ignored bytes between frames; keep them off the start byte
            repeat ($urandom_range(1, 5)) begin
               noise = 8'($urandom_range(0, 255));
               if (noise == FRAME_START_BYTE) noise = ~noise;
               send_byte(noise);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("kind: expected no transaction, actual %0d", rsp_bus.kind);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_bus.kind));
            check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_bus.payload_byte));
            check_field("payload_index", want.payload_index, rsp_bus.payload_index);
            check_field("frame_address", want.frame_address, rsp_bus.frame_address);
            check_field("frame_function", want.frame_function, rsp_bus.frame_function);
            check_field("frame_length", want.frame_length, rsp_bus.frame_length);
            check_field("received_check", want.received_check, rsp_bus.received_check);
         end
      end
   end

   // Result-side back-pressure: switch among stall patterns every so often.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_cycle++;
      case (stall_mode)
         RX_ALWAYS: rsp_bus.ready = 1'b1;
         RX_MOSTLY: rsp_bus.ready = ($urandom_range(0, 3) != 0);
         RX_RARELY: rsp_bus.ready = ($urandom_range(0, 3) == 0);
         default:   rsp_bus.ready = (stall_cycle % 5 != 0);
      endcase
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_hunt_noise();
      test_zero_length_frame();
      test_bad_second_end();
      test_bad_first_end();
      test_long_frame();
      test_random_frames();

      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("framed_packet_byte_parser_test: PASS");
      end else begin
         $display("framed_packet_byte_parser_test: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/fpbp_pkg.sv
rtl/core/fpbp_if.sv
rtl/core/fpbp_in_stage.sv
rtl/core/fpbp_parse.sv
rtl/core/fpbp_out_stage.sv
rtl/core/framed_packet_byte_parser.sv
rtl/core/fpbp_checker.sv
tb/framed_packet_byte_parser_test.sv
